// ----- rtl/core/bb3_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bb3_pkg: shared definitions for the 3x3 box blur
// Sizes, register indexes, cell control type and the divide-by-nine helper.
// ----------------------------------------------------------------------------
package bb3_pkg;

    localparam int MAX_COLS   = 32;
    localparam int COL_W      = $clog2(MAX_COLS + 1);
    localparam int IDX_W      = $clog2(MAX_COLS);
    localparam int LEAD_W     = COL_W + 1;

    localparam int PIX_W      = 8;
    localparam int CFG_COLS_W = 6;
    localparam int CFG_ROWS_W = 11;
    localparam int CFG_W      = 11;
    localparam int ROW_W      = 10;
    localparam int ROWS_LIMIT = 1024;

    // mean of nine taps by reciprocal multiply, exact for sums below 2296
    localparam int SUM_W      = 12;
    localparam int AVG_DIV    = 9;
    localparam int AVG_SHIFT  = 15;
    localparam int AVG_RECIP  = (2 ** AVG_SHIFT + AVG_DIV - 1) / AVG_DIV;
    localparam int PROD_W     = 2 * SUM_W;

    typedef logic [0:0] reg_index_t;
    localparam reg_index_t REG_FRAME_COLS = 1'b0;
    localparam reg_index_t REG_FRAME_ROWS = 1'b1;

    typedef struct packed {
        logic shift;
        logic load;
    } cell_ctl_t;

    function automatic logic [PIX_W-1:0] avg9(input logic [SUM_W-1:0] sum);
        logic [PROD_W-1:0] prod;
        prod = PROD_W'(sum) * PROD_W'(AVG_RECIP);
        return prod[AVG_SHIFT +: PIX_W];
    endfunction

endpackage

// ----- rtl/core/bb3_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bb3_cell: one pixel cell of a line delay
// Holds one pixel; takes either its neighbor or the row entry value.
// ----------------------------------------------------------------------------
module bb3_cell
    import bb3_pkg::*;
(
    input  logic             clk,
    input  cell_ctl_t        ctl,
    input  logic [PIX_W-1:0] din,
    input  logic [PIX_W-1:0] prev,
    output logic [PIX_W-1:0] q
);

    logic [PIX_W-1:0] pix_reg;
    logic [PIX_W-1:0] pix_next;

    always_comb
    begin
        pix_next = ctl.load ? din : prev;
    end

    always_ff @(posedge clk)
    begin
        if (ctl.shift)
        begin
            pix_reg <= pix_next;
        end
    end

    assign q = pix_reg;

endmodule

// ----- rtl/core/bb3_line.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bb3_line: line delay of one frame row
// A chain of cells; the entry cell is picked so the delay equals the width.
// ----------------------------------------------------------------------------
module bb3_line
    import bb3_pkg::*;
(
    input  logic             clk,
    input  logic             shift,
    input  logic [COL_W-1:0] width,
    input  logic [PIX_W-1:0] din,
    output logic [PIX_W-1:0] dout
);

    logic [COL_W-1:0] entry;
    logic [PIX_W-1:0] tap [MAX_COLS];

    // data enters width cells before the end of the chain
    assign entry = COL_W'(MAX_COLS) - width;

    genvar k;
    generate
        for (k = 0; k < MAX_COLS; k++)
        begin : g_cell
            cell_ctl_t        ctl;
            logic [PIX_W-1:0] prev;

            assign ctl.shift = shift;
            assign ctl.load  = (entry[IDX_W-1:0] == IDX_W'(k));

            if (k == 0)
            begin : g_head
                assign prev = din;
            end
            else
            begin : g_body
                assign prev = tap[k-1];
            end

            bb3_cell u_cell (
                .clk  (clk),
                .ctl  (ctl),
                .din  (din),
                .prev (prev),
                .q    (tap[k])
            );
        end
    endgenerate

    assign dout = tap[MAX_COLS-1];

endmodule

// ----- rtl/core/box_blur_3x3_stream_unit.sv -----
`timescale 1ns / 1ps
// pixel p's mean is summed as pixel p+width+1 enters, then registered in the sum and output stages
// throughput: one pixel per clock unless stalled or flushing; the two row delays are cell chains shifting per advance
// after a frame's last pixel, no input is taken while the tail is flushed on width+1 filler pixels
// reset: asynchronous, active low; frame size returns to 10 x 10, pipeline empty
// ----------------------------------------------------------------------------
// box_blur_3x3_stream_unit: streaming 3x3 box blur
// Interior pixels get the truncated 3x3 mean, border pixels pass through.
// ----------------------------------------------------------------------------
module box_blur_3x3_stream_unit
    import bb3_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [7:0]       s_tdata,   // [7:0] pixel_in
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [7:0]       m_tdata,   // [7:0] pixel_out
    output logic             m_tlast,   // frame_last
    input  logic             cfg_we,
    input  reg_index_t       cfg_addr,
    input  logic [CFG_W-1:0] cfg_wdata
);

    logic [CFG_COLS_W-1:0] cols_reg;
    logic [CFG_ROWS_W-1:0] rows_reg;
    logic [COL_W-1:0]      w_eff;
    logic [CFG_ROWS_W-1:0] h_eff;

    logic                  flush_reg;
    logic                  flush_next;
    logic [LEAD_W-1:0]     lead_reg;
    logic [LEAD_W-1:0]     lead_next;
    logic [COL_W-1:0]      in_col_reg;
    logic [COL_W-1:0]      in_col_next;
    logic [ROW_W-1:0]      in_row_reg;
    logic [ROW_W-1:0]      in_row_next;
    logic [COL_W-1:0]      out_col_reg;
    logic [COL_W-1:0]      out_col_next;
    logic [ROW_W-1:0]      out_row_reg;
    logic [ROW_W-1:0]      out_row_next;

    logic                  accept;
    logic                  advance;
    logic                  emit;
    logic                  lead_full;
    logic                  last_in;
    logic                  last_out;
    logic                  inner;
    logic [PIX_W-1:0]      din;
    logic [PIX_W-1:0]      a_out;
    logic [PIX_W-1:0]      b_out;
    logic [SUM_W-1:0]      sum;

    logic [PIX_W-1:0]      d1_reg;
    logic [PIX_W-1:0]      d2_reg;
    logic [PIX_W-1:0]      a1_reg;
    logic [PIX_W-1:0]      a2_reg;
    logic [PIX_W-1:0]      b1_reg;
    logic [PIX_W-1:0]      b2_reg;

    logic                  s1_valid_reg;
    logic [SUM_W-1:0]      s1_sum_reg;
    logic [PIX_W-1:0]      s1_center_reg;
    logic                  s1_inner_reg;
    logic                  s1_last_reg;
    logic                  s1_take;

    logic                  o_valid_reg;
    logic [PIX_W-1:0]      o_pix_reg;
    logic                  o_last_reg;
    logic                  o_take;

    // effective frame size
    always_comb
    begin
        if (cols_reg == '0)
        begin
            w_eff = COL_W'(1);
        end
        else if (cols_reg > CFG_COLS_W'(MAX_COLS))
        begin
            w_eff = COL_W'(MAX_COLS);
        end
        else
        begin
            w_eff = COL_W'(cols_reg);
        end

        if (rows_reg == '0)
        begin
            h_eff = CFG_ROWS_W'(1);
        end
        else if (rows_reg > CFG_ROWS_W'(ROWS_LIMIT))
        begin
            h_eff = CFG_ROWS_W'(ROWS_LIMIT);
        end
        else
        begin
            h_eff = rows_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cols_reg <= CFG_COLS_W'(10);
            rows_reg <= CFG_ROWS_W'(10);
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_FRAME_COLS: cols_reg <= cfg_wdata[CFG_COLS_W-1:0];
                REG_FRAME_ROWS: rows_reg <= cfg_wdata[CFG_ROWS_W-1:0];
                default:        ;
            endcase
        end
    end

    // handshake and advance of the window
    assign o_take   = !o_valid_reg || m_tready;
    assign s1_take  = !s1_valid_reg || o_take;
    assign s_tready = s1_take && !flush_reg;
    assign accept   = s_tvalid && s_tready;
    // during flush the window keeps moving on filler pixels
    assign advance  = accept || (flush_reg && s1_take);
    assign din      = accept ? s_tdata : '0;

    assign lead_full = (lead_reg == LEAD_W'(w_eff) + LEAD_W'(1));
    assign emit      = advance && lead_full;

    assign last_in  = (in_col_reg == w_eff - COL_W'(1))
                   && ({1'b0, in_row_reg} == h_eff - CFG_ROWS_W'(1));
    assign last_out = (out_col_reg == w_eff - COL_W'(1))
                   && ({1'b0, out_row_reg} == h_eff - CFG_ROWS_W'(1));
    assign inner    = (out_row_reg != '0)
                   && (({1'b0, out_row_reg} + CFG_ROWS_W'(1)) < h_eff)
                   && (out_col_reg != '0)
                   && ((LEAD_W'(out_col_reg) + LEAD_W'(1)) < LEAD_W'(w_eff));

    always_comb
    begin
        flush_next   = flush_reg;
        lead_next    = lead_reg;
        in_col_next  = in_col_reg;
        in_row_next  = in_row_reg;
        out_col_next = out_col_reg;
        out_row_next = out_row_reg;

        if (advance && !lead_full)
        begin
            lead_next = lead_reg + LEAD_W'(1);
        end

        if (accept)
        begin
            if (last_in)
            begin
                flush_next  = 1'b1;
                in_col_next = '0;
                in_row_next = '0;
            end
            else if (in_col_reg == w_eff - COL_W'(1))
            begin
                in_col_next = '0;
                in_row_next = in_row_reg + ROW_W'(1);
            end
            else
            begin
                in_col_next = in_col_reg + COL_W'(1);
            end
        end

        if (emit)
        begin
            if (last_out)
            begin
                flush_next   = 1'b0;
                lead_next    = '0;
                out_col_next = '0;
                out_row_next = '0;
            end
            else if (out_col_reg == w_eff - COL_W'(1))
            begin
                out_col_next = '0;
                out_row_next = out_row_reg + ROW_W'(1);
            end
            else
            begin
                out_col_next = out_col_reg + COL_W'(1);
            end
        end

        // a register write drops the frame in progress
        if (cfg_we)
        begin
            flush_next   = 1'b0;
            lead_next    = '0;
            in_col_next  = '0;
            in_row_next  = '0;
            out_col_next = '0;
            out_row_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flush_reg   <= 1'b0;
            lead_reg    <= '0;
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
        end
        else
        begin
            flush_reg   <= flush_next;
            lead_reg    <= lead_next;
            in_col_reg  <= in_col_next;
            in_row_reg  <= in_row_next;
            out_col_reg <= out_col_next;
            out_row_reg <= out_row_next;
        end
    end

    // two row delays, then three taps per row
    bb3_line u_line_a (
        .clk   (clk),
        .shift (advance),
        .width (w_eff),
        .din   (din),
        .dout  (a_out)
    );

    bb3_line u_line_b (
        .clk   (clk),
        .shift (advance),
        .width (w_eff),
        .din   (a_out),
        .dout  (b_out)
    );

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            d1_reg <= din;
            d2_reg <= d1_reg;
            a1_reg <= a_out;
            a2_reg <= a1_reg;
            b1_reg <= b_out;
            b2_reg <= b1_reg;
        end
    end

    assign sum = SUM_W'(din) + SUM_W'(d1_reg) + SUM_W'(d2_reg)
               + SUM_W'(a_out) + SUM_W'(a1_reg) + SUM_W'(a2_reg)
               + SUM_W'(b_out) + SUM_W'(b1_reg) + SUM_W'(b2_reg);

    // sum stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s1_take)
        begin
            s1_valid_reg <= emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_take && emit)
        begin
            s1_sum_reg    <= sum;
            s1_center_reg <= a1_reg;
            s1_inner_reg  <= inner;
            s1_last_reg   <= last_out;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            o_valid_reg <= 1'b0;
        end
        else if (o_take)
        begin
            o_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (o_take && s1_valid_reg)
        begin
            o_pix_reg  <= s1_inner_reg ? avg9(s1_sum_reg) : s1_center_reg;
            o_last_reg <= s1_last_reg;
        end
    end

    assign m_tvalid = o_valid_reg;
    assign m_tdata  = o_pix_reg;
    assign m_tlast  = o_last_reg;

`ifndef SYNTHESIS
    a_no_request_in_flush: assert property (
        @(posedge clk) disable iff (!rst_n)
        flush_reg |-> !s_tready
    ) else $error("input request taken during flush");

    a_last_only_in_flush: assert property (
        @(posedge clk) disable iff (!rst_n)
        (emit && last_out && !cfg_we) |-> flush_reg
    ) else $error("frame end emitted before last input");

    a_lead_bounded: assert property (
        @(posedge clk) disable iff (!rst_n)
        lead_reg <= LEAD_W'(w_eff) + LEAD_W'(1)
    ) else $error("lead counter beyond window delay");

    a_flush_ends: assert property (
        @(posedge clk) disable iff (!rst_n)
        (emit && last_out && !cfg_we) |=> !flush_reg && (lead_reg == '0)
    ) else $error("flush not closed after frame end");
`endif

endmodule

// ----- verif/tb_box_blur_3x3_stream_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_box_blur_3x3_stream_unit: self-checking bench for the 3x3 box blur
// Streams frames of many sizes through the unit, most under random stalls on both
// sides, predicts each output pixel and end-of-frame mark, and compares them.
// ----------------------------------------------------------------------------
module tb_box_blur_3x3_stream_unit;
    import bb3_pkg::*;

    localparam int HIST_LEN     = 2 * MAX_COLS + 3;
    localparam int DRAIN_CYCLES = 2 * MAX_COLS + 16;
    localparam int MAX_FLUSH    = 64;
    localparam int MAX_CUT      = 24;

    typedef struct packed {
        logic [PIX_W-1:0] pix;
        logic             is_last;
    } blur_result_t;

    typedef enum {FILL_RANDOM, FILL_BRIGHT, FILL_DARK, FILL_EXTREME} fill_mode_t;

    class blur_scoreboard;
        int cols_cfg;
        int rows_cfg;
        logic [PIX_W-1:0] history [HIST_LEN];
        int in_col, in_row, out_col, out_row;
        blur_result_t expected_q[$];
        int mismatches;

        function new();
            cols_cfg = 10;
            rows_cfg = 10;
            foreach (history[i]) history[i] = '0;
            in_col = 0;
            in_row = 0;
            out_col = 0;
            out_row = 0;
            mismatches = 0;
        endfunction

        function int eff_cols();
            if (cols_cfg == 0) return 1;
            if (cols_cfg > MAX_COLS) return MAX_COLS;
            return cols_cfg;
        endfunction

        function int eff_rows();
            if (rows_cfg == 0) return 1;
            if (rows_cfg > ROWS_LIMIT) return ROWS_LIMIT;
            return rows_cfg;
        endfunction

        function int frame_size();
            return eff_cols() * eff_rows();
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // any write drops the frame in progress, history stays
        function void write_reg(reg_index_t idx, logic [CFG_W-1:0] value);
            if (idx == REG_FRAME_COLS)
                cols_cfg = int'(value[CFG_COLS_W-1:0]);
            else
                rows_cfg = int'(value[CFG_ROWS_W-1:0]);
            in_col = 0;
            in_row = 0;
            out_col = 0;
            out_row = 0;
        endfunction

        // history[0] is the newest pixel, index now in the frame
        function void emit_pixel(int w, int h, int now);
            int pos;
            int center;
            int sum;
            int top;
            blur_result_t res;
            pos = out_row * w + out_col;
            center = now - pos;
            if (out_row >= 1 && out_row + 1 < h && out_col >= 1 && out_col + 1 < w)
            begin
                sum = 0;
                top = center + w + 1;
                for (int dr = 0; dr < 3; dr++)
                    for (int dc = 0; dc < 3; dc++)
                        sum += history[top - dr * w - dc];
                res.pix = PIX_W'(sum / 9);
            end
            else
            begin
                res.pix = history[center];
            end
            res.is_last = (pos + 1 == w * h);
            expected_q.push_back(res);
            out_col++;
            if (out_col >= w)
            begin
                out_col = 0;
                out_row++;
            end
        endfunction

        function void note_pixel(logic [PIX_W-1:0] pix);
            int w;
            int h;
            int now;
            int count;
            w = eff_cols();
            h = eff_rows();
            for (int i = HIST_LEN - 1; i > 0; i--)
                history[i] = history[i-1];
            history[0] = pix;
            now = in_row * w + in_col;
            if (now + 1 >= w * h)
            begin
                // frame end: everything still owed comes out now
                count = 0;
                while (count < MAX_FLUSH && out_row * w + out_col < w * h)
                begin
                    emit_pixel(w, h, now);
                    count++;
                end
                in_col = 0;
                in_row = 0;
                out_col = 0;
                out_row = 0;
                return;
            end
            if (now >= w + 1 && out_row * w + out_col <= now)
                emit_pixel(w, h, now);
            in_col++;
            if (in_col >= w)
            begin
                in_col = 0;
                in_row++;
            end
        endfunction

        function void check_result(logic [PIX_W-1:0] pix, logic is_last);
            blur_result_t exp_res;
            if (expected_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected output: pixel %0d last %0b", pix, is_last);
                return;
            end
            exp_res = expected_q.pop_front();
            if (exp_res.pix !== pix || exp_res.is_last !== is_last)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: expected pixel %0d last %0b, got pixel %0d last %0b",
                             exp_res.pix, exp_res.is_last, pix, is_last);
            end
        endfunction
    endclass

    logic             clk;
    logic             rst_n;
    logic             s_tvalid;
    logic             s_tready;
    logic [7:0]       s_tdata;
    logic             m_tvalid;
    logic             m_tready;
    logic [7:0]       m_tdata;
    logic             m_tlast;
    logic             cfg_we;
    reg_index_t       cfg_addr;
    logic [CFG_W-1:0] cfg_wdata;

    int send_idle_pct = 37;
    int recv_idle_pct = 68;

    blur_scoreboard sb = new();

    box_blur_3x3_stream_unit uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #4_000_000;
        $display("tb_box_blur_3x3_stream_unit: FAIL");
        $finish;
    end

    // output side back-pressure
    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            m_tready = ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_result(m_tdata, m_tlast);
    end

    function automatic logic [7:0] pick_pixel(fill_mode_t mode);
        case (mode)
            FILL_BRIGHT:  return 8'($urandom_range(255, 230));
            FILL_DARK:    return 8'($urandom_range(20, 0));
            FILL_EXTREME: return $urandom_range(1) ? 8'hFF : 8'h00;
            default:      return 8'($urandom_range(255, 0));
        endcase
    endfunction

    // one request on the pixel input, valid held high across back-to-back pixels
    task automatic send_pixel(input logic [7:0] pix);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid = 1'b0;
            @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tdata = pix;
        do
            @(posedge clk);
        while (!s_tready);
        sb.note_pixel(pix);
    endtask

    task automatic settle();
        @(negedge clk);
        s_tvalid = 1'b0;
        while (sb.pending() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input reg_index_t idx, input logic [CFG_W-1:0] value);
        @(negedge clk);
        cfg_we = 1'b1;
        cfg_addr = idx;
        cfg_wdata = value;
        @(posedge clk);
        sb.write_reg(idx, value);
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    task automatic run_frame(input logic [CFG_W-1:0] cols_val, input logic [CFG_W-1:0] rows_val,
                             input fill_mode_t mode, input bit cut, output int sent);
        int n;
        write_reg(REG_FRAME_COLS, cols_val);
        write_reg(REG_FRAME_ROWS, rows_val);
        n = sb.frame_size();
        // a cut frame is abandoned by the next register write, after a short stretch
        if (cut && n > 1)
            n = $urandom_range((n > MAX_CUT) ? MAX_CUT : n - 1, 1);
        for (int i = 0; i < n; i++)
            send_pixel(pick_pixel(mode));
        settle();
        sent = n;
    endtask

    initial
    begin
        logic [7:0] opening [12];
        int random_items;
        int sent;
        logic [CFG_W-1:0] cols_val;
        logic [CFG_W-1:0] rows_val;

        opening = '{8'h00, 8'hFF, 8'h01, 8'hFE, 8'h80, 8'h7F,
                    8'h55, 8'hAA, 8'h00, 8'hFF, 8'hFF, 8'h00};
        random_items = 0;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        cfg_we = 1'b0;
        cfg_addr = REG_FRAME_COLS;
        cfg_wdata = '0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // partial frame at the 10 x 10 reset size, then dropped by a write
        foreach (opening[i])
            send_pixel(opening[i]);
        settle();
        write_reg(REG_FRAME_COLS, 11'd3);
        write_reg(REG_FRAME_ROWS, 11'd3);

        // smallest frame with an interior: full-scale sum in the center
        repeat (9) send_pixel(8'hFF);
        settle();

        // zero sizes act as a single pixel
        write_reg(REG_FRAME_COLS, 11'd0);
        write_reg(REG_FRAME_ROWS, 11'd0);
        send_pixel(8'hA5);
        settle();

        while (random_items < 80)
        begin
            if (random_items < 27)
            begin
                send_idle_pct = 37;
                recv_idle_pct = 68;
            end
            else if (random_items < 54)
            begin
                send_idle_pct = 68;
                recv_idle_pct = 37;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            if ($urandom_range(5) == 0)
            begin
                cols_val = CFG_W'($urandom_range(MAX_COLS, 9));
                rows_val = CFG_W'($urandom_range(3, 1));
            end
            else
            begin
                cols_val = CFG_W'($urandom_range(8, 0));
                rows_val = CFG_W'($urandom_range(7, 0));
            end
            run_frame(cols_val, rows_val, fill_mode_t'($urandom_range(3)),
                      $urandom_range(7) == 0, sent);
            random_items += sent;
        end

        // size extremes, including values that clamp
        run_frame(11'h7E3, 11'd1, FILL_EXTREME, 1'b0, sent);
        run_frame(11'd5, 11'd0, FILL_RANDOM, 1'b0, sent);
        run_frame(11'd1, 11'd1024, FILL_RANDOM, 1'b1, sent);
        run_frame(11'd3, 11'd2047, FILL_RANDOM, 1'b1, sent);

        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("tb_box_blur_3x3_stream_unit: PASS");
        else
            $display("tb_box_blur_3x3_stream_unit: FAIL");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/core/bb3_pkg.sv
rtl/core/bb3_cell.sv
rtl/core/bb3_line.sv
rtl/core/box_blur_3x3_stream_unit.sv
verif/tb_box_blur_3x3_stream_unit.sv
